// ===== design/assert_macros.svh =====
// Assertion macros shared by the divider RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a boolean on every rising clock edge outside reset.
`define RSD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RSD_ASSERT_IMPL(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/rsd_pkg.sv =====
// Types and constants of the rounding signed divider.
package rsd_pkg;

  localparam int DATA_WIDTH = 32;

  localparam logic [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    logic                         div_by_zero;
    logic                         overflow;
  } out_t;

  // One slot of the divide pipeline: partial remainder and a shift
  // register that loses dividend bits at the top and gains quotient bits
  // at the bottom.
  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] dvd;
    logic [DATA_WIDTH-1:0] ay;
    logic                  neg;
    logic                  dz;
  } stage_t;

endpackage

// ===== design/rounding_signed_divider_top.sv =====
// Top level of the pipelined rounding signed divider.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------
//   in      | input     | in_valid/in_stall | rsd_pkg::in_t  (dividend, divisor)
//   out     | output    | out_valid/out_stall | rsd_pkg::out_t (quotient, flags)
//
// One transfer per cycle in each direction when the output side does not stall.
// Pipeline order: the entry stage takes magnitudes, then one restoring
// step per quotient bit (DATA_WIDTH stages), then the round stage, then the sign
// stage, which saturates into the output register.
// Synchronous active-low reset clears every valid bit; payload is not reset.
// A stalled result freezes the whole pipeline, so in_stall follows out_stall
// whenever a result is waiting; nothing is dropped or repeated.
module rounding_signed_divider_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rsd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rsd_pkg::out_t out_data
);

`include "assert_macros.svh"

  localparam int W = rsd_pkg::DATA_WIDTH;

  // Advance every stage unless a finished result is held by the receiver.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------
  // Entry stage: magnitudes and sign bookkeeping.
  // ---------------------------------------------------------------
  logic [W-1:0] x_u;
  logic [W-1:0] y_u;
  logic [W-1:0] ax;
  logic [W-1:0] ay;

  assign x_u = in_data.dividend;
  assign y_u = in_data.divisor;
  assign ax  = x_u[W-1] ? (W'(0) - x_u) : x_u;
  assign ay  = y_u[W-1] ? (W'(0) - y_u) : y_u;

  rsd_pkg::stage_t mag_r;
  rsd_pkg::stage_t mag_nxt;

  always_comb begin
    mag_nxt.valid = in_valid;
    mag_nxt.rem   = '0;
    mag_nxt.dvd   = ax;
    mag_nxt.ay    = ay;
    mag_nxt.neg   = x_u[W-1] ^ y_u[W-1];
    mag_nxt.dz    = (ay == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r.valid <= 1'b0;
    end else if (adv) begin
      mag_r.valid <= mag_nxt.valid;
    end
    if (adv) begin
      mag_r.rem <= mag_nxt.rem;
      mag_r.dvd <= mag_nxt.dvd;
      mag_r.ay  <= mag_nxt.ay;
      mag_r.neg <= mag_nxt.neg;
      mag_r.dz  <= mag_nxt.dz;
    end
  end

  // ---------------------------------------------------------------
  // Divide array: one quotient bit per stage, MSB first.
  // ---------------------------------------------------------------
  rsd_pkg::stage_t chain [W+1];

  assign chain[0] = mag_r;

  for (genvar g = 0; g < W; g++) begin : g_div
    rsd_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .stg_i (chain[g]),
      .stg_o (chain[g+1])
    );
  end

  // ---------------------------------------------------------------
  // Round stage: bump the quotient when twice the remainder reaches the
  // divisor. The magnitude never exceeds the sign weight, so W bits hold it.
  // ---------------------------------------------------------------
  rsd_pkg::stage_t dq;
  logic            rnd_up;
  logic [W-1:0]    q_nxt;

  assign dq     = chain[W];
  assign rnd_up = ({dq.rem, 1'b0} >= {1'b0, dq.ay});
  assign q_nxt  = dq.dvd + W'(rnd_up);

  logic         rnd_valid_r;
  logic [W-1:0] rnd_q_r;
  logic         rnd_neg_r;
  logic         rnd_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_valid_r <= 1'b0;
    end else if (adv) begin
      rnd_valid_r <= dq.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rnd_q_r   <= q_nxt;
      rnd_neg_r <= dq.neg;
      rnd_dz_r  <= dq.dz;
    end
  end

  // ---------------------------------------------------------------
  // Sign stage and output register: zero on divide by zero, negate for
  // mixed signs, saturate a positive quotient that spills past the range.
  // ---------------------------------------------------------------
  rsd_pkg::out_t res_nxt;

  always_comb begin
    res_nxt.div_by_zero = rnd_dz_r;
    res_nxt.overflow    = 1'b0;
    if (rnd_dz_r) begin
      res_nxt.quotient = '0;
    end else if (rnd_neg_r) begin
      res_nxt.quotient = W'(0) - rnd_q_r;
    end else if (rnd_q_r > rsd_pkg::QMAX) begin
      res_nxt.quotient = rsd_pkg::QMAX;
      res_nxt.overflow = 1'b1;
    end else begin
      res_nxt.quotient = rnd_q_r;
    end
  end

  logic          out_valid_r;
  rsd_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rnd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `RSD_ASSERT(a_flags_exclusive, !(out_valid && out_data.div_by_zero && out_data.overflow), "divide by zero and overflow both set")
  `RSD_ASSERT_IMPL(a_dz_zero, out_valid && out_data.div_by_zero, out_data.quotient == '0, "divide by zero with nonzero quotient")
  `RSD_ASSERT_IMPL(a_ovf_sat, out_valid && out_data.overflow, out_data.quotient == rsd_pkg::QMAX, "overflow without saturated quotient")

endmodule

// ===== design/rsd_div_stage.sv =====
// One restoring divide step with its pipeline register.
module rsd_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  rsd_pkg::stage_t stg_i,
  output rsd_pkg::stage_t stg_o
);

  rsd_pkg::stage_t stg_r;
  rsd_pkg::stage_t stg_nxt;

  logic [rsd_pkg::DATA_WIDTH:0] trial;
  logic [rsd_pkg::DATA_WIDTH:0] diff;
  logic                         qbit;

  always_comb begin
    trial   = {stg_i.rem, stg_i.dvd[rsd_pkg::DATA_WIDTH-1]};
    diff    = trial - {1'b0, stg_i.ay};
    qbit    = (trial >= {1'b0, stg_i.ay});
    stg_nxt = stg_i;
    stg_nxt.rem = qbit ? diff[rsd_pkg::DATA_WIDTH-1:0] : trial[rsd_pkg::DATA_WIDTH-1:0];
    stg_nxt.dvd = {stg_i.dvd[rsd_pkg::DATA_WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (en) begin
      stg_r.valid <= stg_nxt.valid;
    end
    // Payload needs no reset; hold it while stalled.
    if (en) begin
      stg_r.rem <= stg_nxt.rem;
      stg_r.dvd <= stg_nxt.dvd;
      stg_r.ay  <= stg_nxt.ay;
      stg_r.neg <= stg_nxt.neg;
      stg_r.dz  <= stg_nxt.dz;
    end
  end

  assign stg_o = stg_r;

endmodule
